// ----- src/pdfm_pkg.sv -----
// Shared types and constants for the PWM duty and frequency meter.
// Used by the controller, the datapath and the top level.
package pdfm_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CLK_W          = 24;
  localparam int DUTY_W         = 7;
  localparam int FREQ_W         = 24;
  localparam int OUT_DATA_W     = 32;
  localparam int IN_USER_W      = 2;
  localparam int PERCENT        = 100;

  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 24'd1000000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef struct packed {
    logic cap_rise;
    logic cap_fall;
    logic cap_period;
    logic div_start;
    logic div_sel_freq;
    logic save_duty;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_period;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/pdfm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by pdfm_dp.
module pdfm_div #(
  parameter int DW = 24,
  parameter int PW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [PW-1:0] rem;
  logic [CW-1:0] count;
  logic          busy;
  logic [PW-1:0] dvs;

  logic [PW:0]   rem_sh;
  logic [PW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quo[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[PW-1:0] : rem_sh[PW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ----- src/pdfm_dp.sv -----
// Datapath: timestamp registers, high time and period, clock register,
// shared divider and output register. Depends on pdfm_pkg and pdfm_div.
module pdfm_dp #(
  parameter int TIMER_BITS = pdfm_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [TIMER_BITS-1:0]            capture_time,
  input  logic                             cfg_we,
  input  logic [pdfm_pkg::CLK_W-1:0]       cfg_wdata,
  input  pdfm_pkg::ctrl_cmd_t              cmd,
  output pdfm_pkg::dp_stat_t               stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [pdfm_pkg::DUTY_W-1:0]      duty_percent,
  output logic [pdfm_pkg::FREQ_W-1:0]      frequency_hz,
  output logic                             zero_period
);

  localparam int PW = TIMER_BITS + 1;
  localparam int HW = TIMER_BITS + pdfm_pkg::DUTY_W;
  localparam int DW = (HW > pdfm_pkg::CLK_W) ? HW : pdfm_pkg::CLK_W;

  logic [TIMER_BITS-1:0]     first_rise_time;
  logic [TIMER_BITS-1:0]     fall_time;
  logic [TIMER_BITS-1:0]     high;
  logic [PW-1:0]             period;
  logic [pdfm_pkg::CLK_W-1:0] clk_hz;
  logic [pdfm_pkg::DUTY_W-1:0] duty_q;

  logic [TIMER_BITS-1:0]     high_next;
  logic [TIMER_BITS-1:0]     low_next;
  logic [DW-1:0]             dividend;
  logic [DW-1:0]             quotient;
  logic                      div_done;

  assign high_next = fall_time - first_rise_time;
  assign low_next  = capture_time - fall_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_rise_time <= '0;
      fall_time       <= '0;
      clk_hz          <= pdfm_pkg::CLK_HZ_RESET;
    end else begin
      if (cmd.cap_rise) begin
        first_rise_time <= capture_time;
      end
      if (cmd.cap_fall) begin
        fall_time <= capture_time;
      end
      if (cfg_we) begin
        clk_hz <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_period) begin
      high   <= high_next;
      period <= {1'b0, high_next} + {1'b0, low_next};
    end
    if (cmd.save_duty) begin
      duty_q <= quotient[pdfm_pkg::DUTY_W-1:0];
    end
  end

  always_comb begin
    if (cmd.div_sel_freq) begin
      dividend = DW'(clk_hz);
    end else begin
      dividend = {{(DW - TIMER_BITS){1'b0}}, high} * DW'(pdfm_pkg::PERCENT);
    end
  end

  pdfm_div #(
    .DW(DW),
    .PW(PW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (period),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      zero_period  <= stat.zero_period;
      duty_percent <= stat.zero_period ? '0 : duty_q;
      frequency_hz <= stat.zero_period ? '0 : quotient[pdfm_pkg::FREQ_W-1:0];
    end
  end

  assign stat.zero_period = (period == '0);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

// ----- src/pdfm_ctrl.sv -----
// Controller: measurement phase tracking and the compute sequence.
// Depends on pdfm_pkg for command and status types and op codes.
module pdfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic                 in_rising,
  input  pdfm_pkg::dp_stat_t   stat,
  output pdfm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] PH_RISE1 = 2'd0;
  localparam logic [1:0] PH_FALL  = 2'd1;
  localparam logic [1:0] PH_RISE2 = 2'd2;
  localparam logic [1:0] PH_IDLE  = 2'd3;

  localparam logic [2:0] S_IN    = 3'd0;
  localparam logic [2:0] S_DUTY  = 3'd1;
  localparam logic [2:0] S_DWAIT = 3'd2;
  localparam logic [2:0] S_FREQ  = 3'd3;
  localparam logic [2:0] S_FWAIT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       accept;

  assign in_ready = (state == S_IN);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    unique case (state)
      S_IN: begin
        if (accept) begin
          if (in_op == pdfm_pkg::OP_START) begin
            phase_next = PH_RISE1;
          end else begin
            unique case (phase)
              PH_RISE1: begin
                if (in_rising) begin
                  cmd.cap_rise = 1'b1;
                  phase_next   = PH_FALL;
                end
              end
              PH_FALL: begin
                if (!in_rising) begin
                  cmd.cap_fall = 1'b1;
                  phase_next   = PH_RISE2;
                end
              end
              PH_RISE2: begin
                if (in_rising) begin
                  cmd.cap_period = 1'b1;
                  phase_next     = PH_IDLE;
                  state_next     = S_DUTY;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_DUTY: begin
        if (stat.zero_period) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.save_duty = 1'b1;
          state_next    = S_FREQ;
        end
      end
      S_FREQ: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_freq = 1'b1;
        state_next       = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.div_sel_freq = 1'b1;
        if (stat.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IN;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// ----- src/pwm_duty_frequency_meter_core.sv -----
// Top level of the PWM duty and frequency meter.
// Depends on pdfm_pkg, pdfm_ctrl and pdfm_dp.
//
// Input stream (s_*): each item is a start command or a captured edge.
// A start arms the meter; it then takes a rising, a falling and a second
// rising edge and ignores edges of the wrong polarity. Edges while idle
// are dropped. The second rising edge produces one result item on m_*.
// Start and edge items that produce no result leave s_tready high.
// The completing edge holds s_tready low while the shared divider runs
// two quotients (duty, then frequency), one quotient bit per cycle, of
// width DW = max(TIMER_BITS + 7, 24). A zero period skips the divider.
// The result sits in an output register; new input items are taken while
// it waits, and the next result waits only if that register is still full.
// cfg_we writes the timer clock rate (reset 1000000 Hz); write it only
// while the block is idle. Reset clears the phase to idle and drops any
// pending result.
module pwm_duty_frequency_meter_core #(
  parameter int TIMER_BITS = pdfm_pkg::TIMER_BITS_DEF,
  localparam int IN_DATA_W = ((TIMER_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [IN_DATA_W-1:0]               s_tdata,   // capture_time, zero pad
  input  logic [pdfm_pkg::IN_USER_W-1:0]     s_tuser,   // op, edge_rising
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pdfm_pkg::OUT_DATA_W-1:0]    m_tdata,   // duty_percent, frequency_hz, zero pad
  output logic [0:0]                         m_tuser,   // zero_period
  input  logic                               cfg_we,
  input  logic [pdfm_pkg::CLK_W-1:0]         cfg_wdata
);

  pdfm_pkg::ctrl_cmd_t cmd;
  pdfm_pkg::dp_stat_t  stat;

  logic [pdfm_pkg::DUTY_W-1:0] duty_percent;
  logic [pdfm_pkg::FREQ_W-1:0] frequency_hz;
  logic                        zero_period;

  pdfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_rising (s_tuser[1]),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdfm_dp #(
    .TIMER_BITS(TIMER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .capture_time (s_tdata[TIMER_BITS-1:0]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .duty_percent (duty_percent),
    .frequency_hz (frequency_hz),
    .zero_period  (zero_period)
  );

  assign m_tdata = {{(pdfm_pkg::OUT_DATA_W - pdfm_pkg::FREQ_W - pdfm_pkg::DUTY_W){1'b0}},
                    frequency_hz, duty_percent};
  assign m_tuser = zero_period;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written over an untaken result");

  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !s_tready)
    else $error("input taken while divider runs");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero period result carries nonzero data");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pdfm_pkg::DUTY_W-1:0] <= pdfm_pkg::DUTY_W'(pdfm_pkg::PERCENT))
    else $error("duty above one hundred percent");

endmodule
